>>> sv/hkre_pkg.sv
package hkre_pkg;

  localparam int unsigned CODE_W        = 8;
  localparam int unsigned MOD_COUNT     = 8;
  localparam int unsigned KEY_SLOTS     = 6;
  localparam int unsigned LIST_LEN      = MOD_COUNT + KEY_SLOTS;
  localparam int unsigned LIST_AW       = $clog2(LIST_LEN);
  localparam int unsigned LIST_IW       = $clog2(LIST_LEN + 1);
  localparam int unsigned IN_W          = CODE_W * (1 + KEY_SLOTS);
  localparam int unsigned HELD_SLOTS_DEF = 16;

  localparam logic [CODE_W-1:0] MOD_BASE      = 8'hE0;
  localparam logic [CODE_W-1:0] ROLLOVER_CODE = 8'h01;

  // codes reported by one item: modifiers in bit order, then the keys
  typedef struct packed {
    logic [LIST_LEN-1:0][CODE_W-1:0] code;
    logic [LIST_LEN-1:0]             vld;
  } list_t;

endpackage

>>> sv/hkre_match.sv
module hkre_match (
  input  logic [hkre_pkg::CODE_W-1:0]   code_i,
  input  hkre_pkg::list_t               list_i,
  output logic [hkre_pkg::LIST_LEN-1:0] match_o
);
  import hkre_pkg::*;

  // one code against every live list entry
  always_comb begin
    for (int i = 0; i < LIST_LEN; i++) begin
      match_o[i] = list_i.vld[i] && (list_i.code[i] == code_i);
    end
  end

endmodule

>>> sv/hkre_ring.sv
module hkre_ring #(
  parameter int unsigned DEPTH = hkre_pkg::HELD_SLOTS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [hkre_pkg::CODE_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [hkre_pkg::CODE_W-1:0] rdata_o
);
  import hkre_pkg::*;

  logic [CODE_W-1:0] mem [DEPTH];
  logic [CODE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/hid_keyboard_report_key_events.sv
// boot keyboard report to key press / release events
//
// slave stream: one report per item, tdata = modifier byte then six key bytes
// master stream: one key event per item, tdata = usage code, tuser = press,
//   tlast marks the final event of a report; a report with no change yields
//   no event at all
// a key byte of 1 before the first zero (roll-over error) yields one press
//   of code 1 and leaves the held set alone
// held codes live in a small ring memory, oldest at the tail; one compare
//   unit checks a code against all fourteen report entries combinationally
// per report, the release pass reads each held entry through the registered
//   ring read, then the press pass checks each report entry and inserts each
//   new press, dropping the oldest code from a full ring without a release
// s_axis_tready is high only while the sequencer is idle
// events are held back by one so tlast can be set on the final one; a
//   stalled receiver freezes the sequencer at its next event, nothing is lost
// reset empties the ring and the output register; ring contents need none
module hid_keyboard_report_key_events #(
  parameter int unsigned HELD_SLOTS = hkre_pkg::HELD_SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // modifier_bits, key_slot_a .. key_slot_f
  input  logic [hkre_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // event_code
  output logic [hkre_pkg::CODE_W-1:0] m_axis_tdata,
  // is_press
  output logic                        m_axis_tuser,
  // last_event
  output logic                        m_axis_tlast
);
  import hkre_pkg::*;

  localparam int unsigned IW  = $clog2(HELD_SLOTS);
  localparam int unsigned IW1 = IW + 1;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_REL_RD  = 7'b0000010,
    ST_REL_CHK = 7'b0000100,
    ST_PRS_CHK = 7'b0001000,
    ST_EVICT   = 7'b0010000,
    ST_INSERT  = 7'b0100000,
    ST_FLUSH   = 7'b1000000
  } state_e;

  function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
    return (p == IW'(HELD_SLOTS - 1)) ? '0 : p + IW'(1);
  endfunction

  state_e state_q, state_d;

  // captured report and per-entry "already held" flags
  list_t               list_q, list_d, list_in;
  logic                rollover_in;
  logic [LIST_LEN-1:0] held_q, held_d;
  logic [LIST_IW-1:0]  j_q, j_d;
  logic [LIST_AW-1:0]  j_idx;

  // ring pointers, count, and release-pass pointers
  logic [IW-1:0] head_q, head_d, tail_q, tail_d, cnt_q, cnt_d;
  logic [IW-1:0] rd_q, rd_d, wr_q, wr_d, left_q, left_d, keep_q, keep_d;

  // one event held back so the final one gets tlast
  logic              pend_vld_q, pend_vld_d, pend_press_q, pend_press_d;
  logic [CODE_W-1:0] pend_code_q, pend_code_d;

  // output register
  logic              m_vld_q, m_vld_d, m_press_q, m_press_d, m_last_q, m_last_d;
  logic [CODE_W-1:0] m_code_q, m_code_d;

  logic              ring_we, ring_re;
  logic [IW-1:0]     ring_waddr, ring_raddr;
  logic [CODE_W-1:0] ring_wdata, ring_rdata;

  logic [CODE_W-1:0]   cmp_code;
  logic [LIST_LEN-1:0] match;

  logic              out_free, can_emit, emit_req, emit_press, step;
  logic [CODE_W-1:0] emit_code;

  hkre_ring #(
    .DEPTH (HELD_SLOTS),
    .AW    (IW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .re_i    (ring_re),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  hkre_match u_match (
    .code_i  (cmp_code),
    .list_i  (list_q),
    .match_o (match)
  );

  // report decode: keys count up to the first zero byte
  always_comb begin
    logic              run;
    logic [CODE_W-1:0] key;
    run         = 1'b1;
    rollover_in = 1'b0;
    for (int i = 0; i < MOD_COUNT; i++) begin
      list_in.code[i] = MOD_BASE + CODE_W'(i);
      list_in.vld[i]  = s_axis_tdata[i];
    end
    for (int k = 0; k < KEY_SLOTS; k++) begin
      key = s_axis_tdata[CODE_W*(k+1) +: CODE_W];
      list_in.code[MOD_COUNT+k] = key;
      list_in.vld[MOD_COUNT+k]  = run && (key != '0);
      if (run && (key == ROLLOVER_CODE)) begin
        rollover_in = 1'b1;
      end
      if (key == '0) begin
        run = 1'b0;
      end
    end
  end

  assign j_idx    = j_q[LIST_AW-1:0];
  assign out_free = !m_vld_q || m_axis_tready;
  assign can_emit = !pend_vld_q || out_free;

  always_comb begin
    state_d      = state_q;
    list_d       = list_q;
    held_d       = held_q;
    j_d          = j_q;
    head_d       = head_q;
    tail_d       = tail_q;
    cnt_d        = cnt_q;
    rd_d         = rd_q;
    wr_d         = wr_q;
    left_d       = left_q;
    keep_d       = keep_q;
    pend_vld_d   = pend_vld_q;
    pend_code_d  = pend_code_q;
    pend_press_d = pend_press_q;
    m_vld_d      = m_vld_q && !m_axis_tready;
    m_code_d     = m_code_q;
    m_press_d    = m_press_q;
    m_last_d     = m_last_q;
    ring_we      = 1'b0;
    ring_waddr   = wr_q;
    ring_wdata   = ring_rdata;
    ring_re      = 1'b0;
    ring_raddr   = rd_q;
    cmp_code     = ring_rdata;
    emit_req     = 1'b0;
    emit_code    = ring_rdata;
    emit_press   = 1'b0;
    step         = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          list_d = list_in;
          held_d = '0;
          j_d    = '0;
          if (rollover_in) begin
            pend_vld_d   = 1'b1;
            pend_code_d  = ROLLOVER_CODE;
            pend_press_d = 1'b1;
            state_d      = ST_FLUSH;
          end else begin
            rd_d    = tail_q;
            wr_d    = tail_q;
            left_d  = cnt_q;
            keep_d  = '0;
            state_d = ST_REL_RD;
          end
        end
      end
      ST_REL_RD: begin
        if (left_q == '0) begin
          // survivors now packed from the tail
          head_d  = wr_q;
          cnt_d   = keep_q;
          state_d = ST_PRS_CHK;
        end else begin
          ring_re = 1'b1;
          state_d = ST_REL_CHK;
        end
      end
      ST_REL_CHK: begin
        if (|match) begin
          ring_we = 1'b1;
          wr_d    = ptr_inc(wr_q);
          keep_d  = keep_q + IW'(1);
          held_d  = held_q | match;
          step    = 1'b1;
        end else begin
          emit_req = 1'b1;
          step     = can_emit;
        end
        if (step) begin
          rd_d    = ptr_inc(rd_q);
          left_d  = left_q - IW'(1);
          state_d = ST_REL_RD;
        end
      end
      ST_PRS_CHK: begin
        if (j_q == LIST_IW'(LIST_LEN)) begin
          state_d = ST_FLUSH;
        end else if (!list_q.vld[j_idx] || held_q[j_idx]) begin
          j_d = j_q + LIST_IW'(1);
        end else if (cnt_q == IW'(HELD_SLOTS - 1)) begin
          // full ring: fetch the oldest code to drop it
          ring_re    = 1'b1;
          ring_raddr = tail_q;
          state_d    = ST_EVICT;
        end else begin
          state_d = ST_INSERT;
        end
      end
      ST_EVICT: begin
        held_d  = held_q & ~match;
        tail_d  = ptr_inc(tail_q);
        cnt_d   = cnt_q - IW'(1);
        state_d = ST_INSERT;
      end
      ST_INSERT: begin
        cmp_code   = list_q.code[j_idx];
        emit_req   = 1'b1;
        emit_code  = list_q.code[j_idx];
        emit_press = 1'b1;
        if (can_emit) begin
          ring_we    = 1'b1;
          ring_waddr = head_q;
          ring_wdata = list_q.code[j_idx];
          head_d     = ptr_inc(head_q);
          cnt_d      = cnt_q + IW'(1);
          held_d     = held_q | match;
          j_d        = j_q + LIST_IW'(1);
          state_d    = ST_PRS_CHK;
        end
      end
      ST_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          m_vld_d    = 1'b1;
          m_code_d   = pend_code_q;
          m_press_d  = pend_press_q;
          m_last_d   = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // new event pushes the held-back one out
    if (emit_req && can_emit) begin
      if (pend_vld_q) begin
        m_vld_d   = 1'b1;
        m_code_d  = pend_code_q;
        m_press_d = pend_press_q;
        m_last_d  = 1'b0;
      end
      pend_vld_d   = 1'b1;
      pend_code_d  = emit_code;
      pend_press_d = emit_press;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      cnt_q      <= '0;
      pend_vld_q <= 1'b0;
      m_vld_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      cnt_q      <= cnt_d;
      pend_vld_q <= pend_vld_d;
      m_vld_q    <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    list_q       <= list_d;
    held_q       <= held_d;
    j_q          <= j_d;
    rd_q         <= rd_d;
    wr_q         <= wr_d;
    left_q       <= left_d;
    keep_q       <= keep_d;
    pend_code_q  <= pend_code_d;
    pend_press_q <= pend_press_d;
    m_code_q     <= m_code_d;
    m_press_q    <= m_press_d;
    m_last_q     <= m_last_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_code_q;
  assign m_axis_tuser  = m_press_q;
  assign m_axis_tlast  = m_last_q;

  // ring end recomputed from tail and count
  logic [IW1-1:0] ring_sum, ring_end;
  assign ring_sum = {1'b0, tail_q} + {1'b0, cnt_q};
  assign ring_end = (ring_sum >= IW1'(HELD_SLOTS)) ? ring_sum - IW1'(HELD_SLOTS) : ring_sum;

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !pend_vld_q)
    else $error("held-back event left over at idle");

  a_ring_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (ring_end[IW-1:0] == head_q))
    else $error("ring head, tail and count disagree");

  a_rollover_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata == ROLLOVER_CODE)) |-> (m_axis_tuser && m_axis_tlast))
    else $error("roll-over code sent as other than a single final press");

  a_full_before_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVICT) |-> (cnt_q == IW'(HELD_SLOTS - 1)))
    else $error("eviction from a ring that is not full");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import hkre_pkg::*;

  typedef logic [CODE_W-1:0] code_t;
  // key_slot_a in the low byte up to key_slot_f
  typedef logic [KEY_SLOTS-1:0][CODE_W-1:0] key_row_t;

  typedef struct packed {
    code_t code;
    logic  press;
    logic  last;
  } key_event_t;

  localparam int unsigned STALL_LIMIT  = 3000;
  // covers a worst-case report, with margin for receiver stalls
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned RING_CAP     = HELD_SLOTS_DEF - 1;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           s_axis_tvalid;
  logic           s_axis_tready;
  // modifier_bits, key_slot_a .. key_slot_f
  logic [IN_W-1:0] s_axis_tdata;
  logic           m_axis_tvalid;
  logic           m_axis_tready;
  // event_code
  code_t          m_axis_tdata;
  // is_press
  logic           m_axis_tuser;
  // last_event
  logic           m_axis_tlast;

  // predictor state: codes held down, oldest first
  code_t      keys_down[$];
  key_event_t events_due[$];
  int         error_count = 0;
  int         quiet_cycles = 0;
  int         tx_idle_pct = 29;
  int         rx_idle_pct = 29;

  // stimulus side: the keyboard as a user would drive it
  code_t      typed_mods;
  code_t      typed_keys[$];
  key_event_t seen_event;
  key_event_t want_event;

  hid_keyboard_report_key_events uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit code_listed(input code_t set[$], input code_t c);
    foreach (set[i]) begin
      if (set[i] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  // works out the events one accepted report causes and queues them
  task automatic predict_events(input code_t mods, input key_row_t keys);
    code_t      listed[$];
    code_t      kept[$];
    key_event_t batch[$];
    bit         rolled;
    rolled = 1'b0;
    for (int j = 0; j < MOD_COUNT; j++) begin
      if (mods[j]) listed.push_back(MOD_BASE + code_t'(j));
    end
    // key bytes up to the first zero; a roll-over code anywhere there wins
    for (int j = 0; j < KEY_SLOTS && keys[j] != '0 && !rolled; j++) begin
      if (keys[j] == ROLLOVER_CODE) rolled = 1'b1;
      else listed.push_back(keys[j]);
    end
    if (rolled) begin
      batch.push_back('{ROLLOVER_CODE, 1'b1, 1'b0});
    end else begin
      foreach (keys_down[i]) begin
        if (code_listed(listed, keys_down[i])) kept.push_back(keys_down[i]);
        else batch.push_back('{keys_down[i], 1'b0, 1'b0});
      end
      keys_down = kept;
      foreach (listed[j]) begin
        if (!code_listed(keys_down, listed[j])) begin
          keys_down.push_back(listed[j]);
          // full ring loses its oldest code without a release
          if (keys_down.size() > RING_CAP) void'(keys_down.pop_front());
          batch.push_back('{listed[j], 1'b1, 1'b0});
        end
      end
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) events_due.push_back(batch[i]);
  endtask

  // presents one report and holds it until accepted
  task automatic send_report(input code_t mods, input key_row_t keys);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {keys, mods};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_events(mods, keys);
  endtask

  function automatic code_t pick_key_code();
    if ($urandom_range(99) < 85) return code_t'($urandom_range(8'h04, 8'h65));
    return code_t'($urandom_range(8'h02, 8'hff));
  endfunction

  // one step of a plausible typing session: a few presses, releases and
  // modifier changes, now and then a roll-over error, a repeated code or
  // junk after the terminating zero
  task automatic type_step();
    key_row_t row;
    int       roll;
    int       fill;
    int       pos;
    code_t    c;
    code_t    tmp;
    roll = $urandom_range(99);
    row  = '0;
    if (roll < 3) begin
      pos = $urandom_range(KEY_SLOTS-1);
      for (int i = 0; i < KEY_SLOTS; i++) begin
        if (i < pos) row[i] = code_t'($urandom_range(8'h02, 8'hff));
        else if (i > pos) row[i] = code_t'($urandom_range(8'hff));
      end
      row[pos] = ROLLOVER_CODE;
      send_report(code_t'($urandom_range(8'hff)), row);
      return;
    end
    if (roll < 6) begin
      typed_keys.delete();
      typed_mods = '0;
    end else begin
      repeat ($urandom_range(3)) begin
        case ($urandom_range(9))
          0, 1, 2: typed_mods[$urandom_range(MOD_COUNT-1)] ^= 1'b1;
          3, 4, 5, 6: begin
            if (typed_keys.size() < KEY_SLOTS) begin
              do c = pick_key_code(); while (code_listed(typed_keys, c));
              typed_keys.push_back(c);
            end
          end
          default: begin
            if (typed_keys.size() > 0) typed_keys.delete($urandom_range(typed_keys.size()-1));
          end
        endcase
      end
    end
    // some keyboards report in no particular order
    if (typed_keys.size() > 1 && $urandom_range(99) < 20) begin
      pos = $urandom_range(typed_keys.size()-1);
      tmp = typed_keys[0];
      typed_keys[0] = typed_keys[pos];
      typed_keys[pos] = tmp;
    end
    fill = typed_keys.size();
    foreach (typed_keys[i]) row[i] = typed_keys[i];
    if (fill > 0 && fill < KEY_SLOTS && roll < 10) begin
      row[fill] = typed_keys[$urandom_range(fill-1)];
      fill++;
    end
    if ($urandom_range(99) < 15) begin
      for (int i = fill + 1; i < KEY_SLOTS; i++) row[i] = code_t'($urandom_range(8'hff));
    end
    send_report(typed_mods, row);
  endtask

  task automatic test_press_release();
    send_report(8'h00, '0);
    send_report(8'h01, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04});
    send_report(8'hff, {8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04});
    // identical report: nothing changes, no event
    send_report(8'hff, {8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04});
    send_report(8'h80, {8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'h09});
    send_report(8'h00, {8'h03, 8'h02, 8'h7f, 8'h80, 8'hfe, 8'hff});
    send_report(8'h00, '0);
  endtask

  task automatic test_rollover_error();
    send_report(8'h02, {8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'h04});
    send_report(8'h00, {8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01});
    send_report(8'h5a, {8'h01, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04});
    // a 1 past the terminating zero is not an error
    send_report(8'h02, {8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h04});
    send_report(8'h00, '0);
  endtask

  task automatic test_list_handling();
    send_report(8'h10, {8'h00, 8'h00, 8'h00, 8'h05, 8'h04, 8'h00});
    // repeated codes, and a modifier code also sent as a key
    send_report(8'h10, {8'h00, 8'h06, 8'h07, 8'he4, 8'h06, 8'h06});
    send_report(8'h00, {8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h07});
    send_report(8'h81, {8'h00, 8'h00, 8'h00, 8'h00, 8'he7, 8'he0});
    // fourteen codes held at once
    send_report(8'hff, {8'h15, 8'h14, 8'h13, 8'h12, 8'h11, 8'h10});
    send_report(8'h0f, {8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30});
    send_report(8'hf0, {8'h45, 8'h44, 8'h43, 8'h42, 8'h41, 8'h40});
    send_report(8'h00, '0);
  endtask

  task automatic test_random_typing(input int count);
    typed_mods = '0;
    typed_keys.delete();
    repeat (count) type_step();
  endtask

  // raw reports with every byte random, now and then cut short by a zero
  task automatic test_random_noise(input int count);
    key_row_t row;
    int       cut;
    repeat (count) begin
      for (int i = 0; i < KEY_SLOTS; i++) row[i] = code_t'($urandom_range(8'hff));
      cut = $urandom_range(KEY_SLOTS + 2);
      if (cut < KEY_SLOTS) row[cut] = '0;
      send_report(code_t'($urandom_range(8'hff)), row);
    end
  endtask

  // long stretch with neither side idling
  task automatic test_back_to_back(input int count);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (count) type_step();
    tx_idle_pct = 29;
    rx_idle_pct = 29;
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // compares each event leaving the block with the oldest one due
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_event = '{m_axis_tdata, m_axis_tuser, m_axis_tlast};
      if (events_due.size() == 0) begin
        $display("%0t: unexpected event code %h press %b last %b", $time,
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
        error_count++;
      end else begin
        want_event = events_due.pop_front();
        if (seen_event.code !== want_event.code) begin
          $display("%0t: event_code expected %h actual %h", $time,
                   want_event.code, seen_event.code);
          error_count++;
        end
        if (seen_event.press !== want_event.press) begin
          $display("%0t: is_press expected %b actual %b", $time,
                   want_event.press, seen_event.press);
          error_count++;
        end
        if (seen_event.last !== want_event.last) begin
          $display("%0t: last_event expected %b actual %b", $time,
                   want_event.last, seen_event.last);
          error_count++;
        end
      end
    end
  end

  // ends a hung run: no item moving on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_press_release();
    test_rollover_error();
    test_list_handling();
    test_random_typing(330);
    test_random_noise(80);
    test_back_to_back(40);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0 && events_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
